@@ rtl/core/ppjd_pkg.sv @@
`default_nettype none

package ppjd_pkg;

  // Fixed field widths of the request and response items.
  localparam int unsigned CLASS_W  = 3;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned PRIO_W   = 4;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IX_W = 1;

  // Request modes.
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IX_W-1:0] REG_CLASS_PRIORITIES = 1'd0;
  localparam logic [CFG_IX_W-1:0] REG_PREEMPT_ENABLE   = 1'd1;

  localparam logic [CFG_W-1:0] PRIO_RESET = 32'h7654_3210;

  typedef struct packed {
    logic [1:0]          mode;
    logic [CLASS_W-1:0]  class_id;
    logic [HANDLE_W-1:0] job_handle;
    logic                job_done;
  } req_t;

  typedef struct packed {
    logic                push_accepted;
    logic                start_valid;
    logic [CLASS_W-1:0]  start_class;
    logic [HANDLE_W-1:0] start_handle;
    logic                retired;
    logic                preempt_valid;
    logic [CLASS_W-1:0]  preempt_class;
    logic                requeue_lost;
    logic                busy_res;
    logic [CLASS_W-1:0]  running_class;
    logic [COUNT_W-1:0]  class_count;
  } rsp_t;

  // Outcome of the priority selection.
  typedef struct packed {
    logic               found;
    logic [CLASS_W-1:0] cls;
  } pick_t;

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/preemptive_priority_job_dispatcher.sv @@
`default_nettype none

// Strict-priority job dispatcher with optional preemption.
// Requests arrive on req (req_valid/req_ready) and each one yields exactly one
// response on rsp (rsp_valid/rsp_ready). A request is a push of a job handle
// into its class queue, a tick, a flush of all queues, or an occupancy query.
// Configuration is written through cfg_we/cfg_index/cfg_data, by the user
// only while the block is idle (not enforced by the block); index 0 holds
// the per-class priority nibbles, index 1 the preemption enable.
// Pushes, flushes, queries and ticks that start nothing are answered in the
// cycle after acceptance, and a new request may be taken every cycle while
// responses are taken. A tick that starts a job must fetch the head handle
// from the queue memory, whose read data is registered, so it is answered
// only after S_FETCH and blocks the request channel during S_FETCH.
// The response sits in an output register: while the receiver stalls, the
// response is held and a further request is taken only in the cycle in which
// the held response leaves. Reset empties every queue, clears the running job
// and restores the configuration defaults; no clearing pass is needed since
// the handle memory is read only at entries that have been written.
module preemptive_priority_job_dispatcher #(
  parameter int unsigned NUM_CLASSES  = 4,
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned HANDLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_ready,
  input  wire ppjd_pkg::req_t                 req,
  output logic                                rsp_valid,
  input  wire logic                           rsp_ready,
  output ppjd_pkg::rsp_t                      rsp,
  input  wire logic                           cfg_we,
  input  wire logic [ppjd_pkg::CFG_IX_W-1:0]  cfg_index,
  input  wire logic [ppjd_pkg::CFG_W-1:0]     cfg_data
);

  // Stored handle width: the handle field is never wider than its port.
  localparam int unsigned SW    = (HANDLE_WIDTH < ppjd_pkg::HANDLE_W) ?
                                  HANDLE_WIDTH : ppjd_pkg::HANDLE_W;
  localparam int unsigned NI    = $clog2(NUM_CLASSES);
  localparam int unsigned PW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUMW  = QW + 1;
  localparam int unsigned WORDS = NUM_CLASSES * QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(WORDS);

  // Configuration.
  logic [ppjd_pkg::CFG_W-1:0] class_priorities;
  logic                       preempt_enable;

  // Queue bookkeeping and the running job.
  logic [PW-1:0] heads      [NUM_CLASSES];
  logic [PW-1:0] heads_next [NUM_CLASSES];
  logic [QW-1:0] counts      [NUM_CLASSES];
  logic [QW-1:0] counts_next [NUM_CLASSES];
  logic                          running_flag, running_flag_next;
  logic [ppjd_pkg::CLASS_W-1:0]  running_class_reg, running_class_next;
  logic [SW-1:0]                 running_handle;

  ppjd_pkg::state_t state, state_next;
  ppjd_pkg::rsp_t   rsp_next;
  ppjd_pkg::pick_t  pick;

  logic                 accept;
  logic                 start_go;
  logic [NUM_CLASSES-1:0] nonempty;

  logic cid_ok;
  logic [NI-1:0] cid_ix;
  logic [NI-1:0] run_ix;
  logic [NI-1:0] best_ix;
  logic [NI-1:0] tail_ix;
  logic [SUMW-1:0] tail_sum;
  logic [PW-1:0]   tail_slot;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [SW-1:0] wr_data, rd_data;

  assign cid_ok  = (32'(req.class_id) < NUM_CLASSES);
  assign cid_ix  = req.class_id[NI-1:0];
  assign run_ix  = running_class_reg[NI-1:0];
  assign best_ix = pick.cls[NI-1:0];
  assign accept  = req_valid && req_ready;

  always_comb begin
    for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
      nonempty[c] = (counts[c] != '0);
    end
  end

  ppjd_pick #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_pick (
    .prio     (class_priorities),
    .nonempty (nonempty),
    .busy     (running_flag),
    .run_cls  (running_class_reg),
    .pick     (pick)
  );

  // A push appends to the addressed class; a preemption appends the displaced
  // job to the running class. The two never occur on the same request.
  assign tail_ix  = (req.mode == ppjd_pkg::MODE_PUSH) ? cid_ix : run_ix;
  assign tail_sum = SUMW'(heads[tail_ix]) + SUMW'(counts[tail_ix]);
  assign tail_slot = (tail_sum >= SUMW'(QUEUE_DEPTH)) ?
                     PW'(tail_sum - SUMW'(QUEUE_DEPTH)) : PW'(tail_sum);

  ppjd_store #(
    .WORDS (WORDS),
    .AW    (AW),
    .DW    (SW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Request decode: every bookkeeping update is settled in the cycle of
  // acceptance; only the started job's handle waits for the memory read.
  always_comb begin
    heads_next         = heads;
    counts_next        = counts;
    running_flag_next  = running_flag;
    running_class_next = running_class_reg;
    rsp_next           = '0;
    start_go           = 1'b0;
    wr_en              = 1'b0;
    wr_addr            = AW'(tail_ix) * AW'(QUEUE_DEPTH) + AW'(tail_slot);
    wr_data            = req.job_handle[SW-1:0];
    rd_en              = 1'b0;
    rd_addr            = AW'(best_ix) * AW'(QUEUE_DEPTH) + AW'(heads[best_ix]);

    if (accept) begin
      case (req.mode)
        ppjd_pkg::MODE_PUSH: begin
          if (cid_ok && (counts[cid_ix] != QW'(QUEUE_DEPTH))) begin
            wr_en                  = 1'b1;
            counts_next[cid_ix]    = counts[cid_ix] + QW'(1);
            rsp_next.push_accepted = 1'b1;
          end
        end
        ppjd_pkg::MODE_TICK: begin
          if (running_flag && req.job_done) begin
            running_flag_next  = 1'b0;
            running_class_next = '0;
            rsp_next.retired   = 1'b1;
          end else if ((!running_flag || preempt_enable) && pick.found) begin
            start_go            = 1'b1;
            rd_en               = 1'b1;
            heads_next[best_ix] = (heads[best_ix] == PW'(QUEUE_DEPTH - 1)) ?
                                  '0 : heads[best_ix] + PW'(1);
            counts_next[best_ix] = counts[best_ix] - QW'(1);
            if (running_flag) begin
              rsp_next.preempt_valid = 1'b1;
              rsp_next.preempt_class = running_class_reg;
              wr_data                = running_handle;
              if (counts[run_ix] != QW'(QUEUE_DEPTH)) begin
                wr_en               = 1'b1;
                counts_next[run_ix] = counts[run_ix] + QW'(1);
              end else begin
                rsp_next.requeue_lost = 1'b1;
              end
            end
            running_flag_next    = 1'b1;
            running_class_next   = pick.cls;
            rsp_next.start_valid = 1'b1;
            rsp_next.start_class = pick.cls;
          end
        end
        ppjd_pkg::MODE_FLUSH: begin
          for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
            counts_next[c] = '0;
          end
        end
        default: begin
        end
      endcase
    end

    rsp_next.busy_res      = running_flag_next;
    rsp_next.running_class = running_class_next;
    rsp_next.class_count   = cid_ok ? ppjd_pkg::COUNT_W'(counts_next[cid_ix]) : '0;
  end

  // Next state.
  always_comb begin
    case (state)
      ppjd_pkg::S_IDLE:  state_next = start_go ? ppjd_pkg::S_FETCH : ppjd_pkg::S_IDLE;
      ppjd_pkg::S_FETCH: state_next = ppjd_pkg::S_IDLE;
      default:           state_next = ppjd_pkg::S_IDLE;
    endcase
  end

  // State outputs: requests are taken only when no handle fetch is pending
  // and the output register is free or emptying.
  always_comb begin
    case (state)
      ppjd_pkg::S_IDLE:  req_ready = !rsp_valid || rsp_ready;
      ppjd_pkg::S_FETCH: req_ready = 1'b0;
      default:           req_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ppjd_pkg::S_IDLE;
      class_priorities  <= ppjd_pkg::PRIO_RESET;
      preempt_enable    <= 1'b0;
      running_flag      <= 1'b0;
      running_class_reg <= '0;
      running_handle    <= '0;
      rsp_valid         <= 1'b0;
      for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
        heads[c]  <= '0;
        counts[c] <= '0;
      end
    end else begin
      state             <= state_next;
      heads             <= heads_next;
      counts            <= counts_next;
      running_flag      <= running_flag_next;
      running_class_reg <= running_class_next;

      if (cfg_we) begin
        case (cfg_index)
          ppjd_pkg::REG_CLASS_PRIORITIES: class_priorities <= cfg_data;
          ppjd_pkg::REG_PREEMPT_ENABLE:   preempt_enable   <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // The started job's handle arrives from memory in S_FETCH, the cycle after accept.
      if (state == ppjd_pkg::S_FETCH) begin
        running_handle    <= rd_data;
        rsp.start_handle  <= ppjd_pkg::HANDLE_W'(rd_data);
        rsp_valid         <= 1'b1;
      end else if (accept) begin
        rsp       <= rsp_next;
        rsp_valid <= !start_go;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // No response may be presented while its handle is still being fetched.
  a_fetch_holds_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == ppjd_pkg::S_FETCH) |-> !rsp_valid)
    else $error("response presented during handle fetch");

  // A starting tick leaves a running job and a pending fetch behind it.
  a_start_fetch: assert property (@(posedge clk) disable iff (rst)
    (accept && start_go) |=> ((state == ppjd_pkg::S_FETCH) && running_flag))
    else $error("started job not followed by a handle fetch");

  // The fetch completes into a valid response in the following cycle.
  a_fetch_done: assert property (@(posedge clk) disable iff (rst)
    (state == ppjd_pkg::S_FETCH) |=> (rsp_valid && rsp.start_valid))
    else $error("handle fetch did not produce a start response");

  // An idle dispatcher keeps its running class at zero.
  a_idle_class: assert property (@(posedge clk) disable iff (rst)
    !running_flag |-> (running_class_reg == '0))
    else $error("running class set while idle");

endmodule

`default_nettype wire

@@ rtl/core/ppjd_store.sv @@
`default_nettype none

// Handle storage for all class queues: one write port and one read port,
// read data registered.
module ppjd_store #(
  parameter int unsigned WORDS = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ppjd_pick.sv @@
`default_nettype none

// Picks the class to start: lowest priority value among non-empty classes,
// ties to the lower index. While a job runs, only classes whose priority
// value is strictly above that of the running class qualify.
module ppjd_pick #(
  parameter int unsigned NUM_CLASSES = 4
) (
  input  wire logic [ppjd_pkg::CFG_W-1:0]   prio,
  input  wire logic [NUM_CLASSES-1:0]       nonempty,
  input  wire logic                         busy,
  input  wire logic [ppjd_pkg::CLASS_W-1:0] run_cls,
  output ppjd_pkg::pick_t                   pick
);

  logic [ppjd_pkg::PRIO_W-1:0] cur_p;
  logic [ppjd_pkg::PRIO_W-1:0] best_p;
  logic [ppjd_pkg::PRIO_W-1:0] p;

  assign cur_p = prio[{run_cls, 2'b00} +: ppjd_pkg::PRIO_W];

  always_comb begin
    pick   = '0;
    best_p = '0;
    p      = '0;
    for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
      p = prio[c*ppjd_pkg::PRIO_W +: ppjd_pkg::PRIO_W];
      if (nonempty[c] && (!busy || (p > cur_p))) begin
        if (!pick.found || (p < best_p)) begin
          pick.found = 1'b1;
          pick.cls   = ppjd_pkg::CLASS_W'(c);
          best_p     = p;
        end
      end
    end
  end

endmodule

`default_nettype wire
